// ===== rtl/core/ccp_pkg.sv =====
// Shared types, constants and helpers for the ChaCha20-Poly1305 AEAD block.
// Used by ccp_chacha, ccp_mac and chacha20_poly1305_aead; depends on nothing.
`default_nettype none
package ccp_pkg;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [129:0] POLY_P = {2'b11, {31{4'hf}}, 4'hb};
    localparam logic [63:0] R_CLAMP_LO = 64'h0FFFFFFC0FFFFFFF;
    localparam logic [63:0] R_CLAMP_HI = 64'h0FFFFFFC0FFFFFFC;

    localparam logic [1:0] ACT_AD     = 2'd0;
    localparam logic [1:0] ACT_TEXT   = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_NONCEL = 3'd4;
    localparam logic [2:0] REG_NONCEH = 3'd5;
    localparam logic [2:0] REG_DEC    = 3'd6;

    typedef enum logic [1:0] {PH_IDLE, PH_AD, PH_TEXT} phase_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_KS_GO, ST_KS_WAIT, ST_DISP, ST_XOR,
        ST_ABS_GO, ST_ABS_WAIT, ST_TAG, ST_EMIT
    } top_state_t;

    typedef enum logic [1:0] {CC_IDLE, CC_RUN, CC_DONE} cc_state_t;

    typedef enum logic [1:0] {MAC_IDLE, MAC_ADD, MAC_MUL, MAC_DONE} mac_state_t;

    function automatic logic [127:0] byte_mask16(input logic [4:0] n);
        logic [127:0] m;
        m = '0;
        for (int i = 0; i < 16; i++) begin
            m[8*i +: 8] = (5'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] d;
        d = {x, x} << s;
        return d[63:32];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ccp_chacha.sv =====
// ChaCha20 block function computed one quarter-round step per cycle.
// Depends on ccp_pkg; the state rotates its rows so the step unit has fixed taps.
`default_nettype none
module ccp_chacha
    import ccp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [255:0] key,
    input  wire logic [95:0]  nonce,
    input  wire logic [31:0]  ctr,
    output logic              done,
    output logic [511:0]      words
);

    cc_state_t   state_reg, state_next;
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] init_w [16];
    logic [1:0]  step_reg;
    logic [2:0]  qr_reg;
    logic [3:0]  dr_reg;
    logic        diag;
    logic        last_step;
    logic [31:0] a, b, c, d, a2, b2, c2, d2;

    always_comb begin
        init_w[0] = SIGMA0;
        init_w[1] = SIGMA1;
        init_w[2] = SIGMA2;
        init_w[3] = SIGMA3;
        for (int i = 0; i < 8; i++) begin
            init_w[4+i] = key[32*i +: 32];
        end
        init_w[12] = ctr;
        init_w[13] = nonce[31:0];
        init_w[14] = nonce[63:32];
        init_w[15] = nonce[95:64];
    end

    assign diag = qr_reg[2];
    assign last_step = (dr_reg == 4'd9) && (qr_reg == 3'd7) && (step_reg == 2'd3);

    always_comb begin
        a = w_reg[0];
        b = diag ? w_reg[5]  : w_reg[4];
        c = diag ? w_reg[10] : w_reg[8];
        d = diag ? w_reg[15] : w_reg[12];
        a2 = a;
        b2 = b;
        c2 = c;
        d2 = d;
        case (step_reg)
            2'd0: begin
                a2 = a + b;
                d2 = rotl32(d ^ a2, 5'd16);
            end
            2'd1: begin
                c2 = c + d;
                b2 = rotl32(b ^ c2, 5'd12);
            end
            2'd2: begin
                a2 = a + b;
                d2 = rotl32(d ^ a2, 5'd8);
            end
            default: begin
                c2 = c + d;
                b2 = rotl32(b ^ c2, 5'd7);
            end
        endcase
    end

    always_comb begin
        logic [31:0] u [16];
        for (int i = 0; i < 16; i++) begin
            u[i] = w_reg[i];
        end
        u[0] = a2;
        if (diag) begin
            u[5]  = b2;
            u[10] = c2;
            u[15] = d2;
        end else begin
            u[4]  = b2;
            u[8]  = c2;
            u[12] = d2;
        end
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
                w_next[4*r+k] = (step_reg == 2'd3) ? u[4*r+((k+1)%4)] : u[4*r+k];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CC_IDLE: if (start) state_next = CC_RUN;
            CC_RUN:  if (last_step) state_next = CC_DONE;
            CC_DONE: state_next = CC_IDLE;
            default: state_next = CC_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == CC_DONE);
        for (int i = 0; i < 16; i++) begin
            words[32*i +: 32] = w_reg[i] + init_w[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CC_IDLE;
            step_reg  <= '0;
            qr_reg    <= '0;
            dr_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == CC_IDLE && start) begin
                step_reg <= '0;
                qr_reg   <= '0;
                dr_reg   <= '0;
            end else if (state_reg == CC_RUN) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    qr_reg <= qr_reg + 3'd1;
                    if (qr_reg == 3'd7) dr_reg <= dr_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            if (state_reg == CC_IDLE && start) begin
                w_reg[i] <= init_w[i];
            end else if (state_reg == CC_RUN) begin
                w_reg[i] <= w_next[i];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ccp_mac.sv =====
// Poly1305 accumulator: adds a block modulo p, then multiplies by r one bit per cycle.
// Depends on ccp_pkg; the accumulator is always held fully reduced below p.
`default_nettype none
module ccp_mac
    import ccp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         clear,
    input  wire logic [127:0] r_in,
    input  wire logic         start,
    input  wire logic [128:0] m_in,
    output logic              done,
    output logic [129:0]      acc
);

    mac_state_t     state_reg, state_next;
    logic [129:0]   acc_reg;
    logic [129:0]   x_reg;
    logic [127:0]   r_reg;
    logic [6:0]     cnt_reg;
    logic [130:0]   sum;
    logic [129:0]   x_sel;
    logic [131:0]   t;
    logic [129:0]   t_sel;

    assign sum = {1'b0, acc_reg} + {2'b0, m_in};
    assign x_sel = (sum >= {1'b0, POLY_P}) ? 130'(sum - {1'b0, POLY_P}) : sum[129:0];

    always_comb begin
        t = {1'b0, acc_reg, 1'b0} + (r_reg[cnt_reg] ? {2'b0, x_reg} : 132'd0);
        if (t >= {1'b0, POLY_P, 1'b0}) begin
            t_sel = 130'(t - {1'b0, POLY_P, 1'b0});
        end else if (t >= {2'b0, POLY_P}) begin
            t_sel = 130'(t - {2'b0, POLY_P});
        end else begin
            t_sel = t[129:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MAC_IDLE: if (start) state_next = MAC_ADD;
            MAC_ADD:  state_next = MAC_MUL;
            MAC_MUL:  if (cnt_reg == 7'd0) state_next = MAC_DONE;
            MAC_DONE: state_next = MAC_IDLE;
            default:  state_next = MAC_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == MAC_DONE);
        acc  = acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MAC_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (clear) begin
                acc_reg <= '0;
            end else if (state_reg == MAC_ADD) begin
                acc_reg <= '0;
                cnt_reg <= 7'd127;
            end else if (state_reg == MAC_MUL) begin
                acc_reg <= t_sel;
                cnt_reg <= cnt_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) r_reg <= r_in;
        if (state_reg == MAC_ADD) x_reg <= x_sel;
    end

    a_acc_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg < POLY_P)
        else $error("Poly1305 accumulator left the reduced range.");

    a_x_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == MAC_MUL) |-> (x_reg < POLY_P))
        else $error("Multiplicand is not reduced during the multiply.");

    a_mul_from_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == MAC_ADD) |=> (state_reg == MAC_MUL && cnt_reg == 7'd127))
        else $error("Multiply did not start from the top bit of r.");

endmodule
`default_nettype wire

// ===== rtl/core/chacha20_poly1305_aead.sv =====
// Top level of the ChaCha20-Poly1305 AEAD engine with its APB register file.
// Depends on ccp_pkg, ccp_chacha and ccp_mac.
//
//   Channel  Direction  Beat contents
//   s_       in         action, data_low, data_high, byte_count
//   m_       out        kind, out_low, out_high, out_count, tag_ok, order_error
//   APB      in/out     key, nonce and decrypt_mode registers, 64-bit data
//
// From one accepted beat to the next, an associated-data block runs dispatch and the
// bit-serial Poly1305 multiply; a text block also runs the XOR and emit states, and every
// fourth text block first runs the ChaCha20 block. A finish runs the multiply, the tag
// and emit states; an empty block only dispatch. A message's first beat also runs ChaCha20.
// Reset is synchronous and active low. A result waiting on m_ready holds the
// engine only once the next result is ready to leave.
`default_nettype none
module chacha20_poly1305_aead
    import ccp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [63:0] s_data_low,
    input  wire logic [63:0] s_data_high,
    input  wire logic [4:0]  s_byte_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [63:0]      m_out_low,
    output logic [63:0]      m_out_high,
    output logic [4:0]       m_out_count,
    output logic             m_tag_ok,
    output logic             m_order_error
);

    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg, nonce_lo_reg;
    logic [31:0]  nonce_hi_reg;
    logic         dec_reg;
    logic [2:0]   reg_idx;

    top_state_t   state_reg, state_next;
    phase_t       phase_reg;
    logic         closed_reg, err_reg, start_flag_reg;
    logic [31:0]  bc_reg, ks_ctr_reg;
    logic [63:0]  ad_len_reg, txt_len_reg;
    logic [1:0]   act_reg;
    logic [63:0]  lo_reg, hi_reg;
    logic [4:0]   n_reg;
    logic [127:0] ks_reg [4];
    logic [127:0] pad_reg;
    logic [128:0] m_blk_reg;
    logic         res_kind_reg, res_ok_reg, res_err_reg;
    logic [127:0] res_data_reg;
    logic [4:0]   res_count_reg;
    logic         m_valid_reg, m_kind_reg, m_tag_ok_reg, m_err_reg;
    logic [127:0] m_data_reg;
    logic [4:0]   m_count_reg;

    logic         accept, cc_start, cc_done, mac_start, mac_done, mac_clear, emit_fire;
    logic [511:0] cc_words;
    logic [129:0] acc;
    logic [127:0] blk_mask, blk_in, text_x, tag;
    logic [127:0] r_clamped;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    always_comb begin
        case (reg_idx)
            REG_KEY0:   prdata = key0_reg;
            REG_KEY1:   prdata = key1_reg;
            REG_KEY2:   prdata = key2_reg;
            REG_KEY3:   prdata = key3_reg;
            REG_NONCEL: prdata = nonce_lo_reg;
            REG_NONCEH: prdata = {32'd0, nonce_hi_reg};
            REG_DEC:    prdata = {63'd0, dec_reg};
            default:    prdata = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
            dec_reg      <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_KEY0:   key0_reg     <= pwdata;
                REG_KEY1:   key1_reg     <= pwdata;
                REG_KEY2:   key2_reg     <= pwdata;
                REG_KEY3:   key3_reg     <= pwdata;
                REG_NONCEL: nonce_lo_reg <= pwdata;
                REG_NONCEH: nonce_hi_reg <= pwdata[31:0];
                REG_DEC:    dec_reg      <= pwdata[0];
                default:    ;
            endcase
        end
    end

    ccp_chacha u_chacha (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cc_start),
        .key     ({key3_reg, key2_reg, key1_reg, key0_reg}),
        .nonce   ({nonce_hi_reg, nonce_lo_reg}),
        .ctr     (ks_ctr_reg),
        .done    (cc_done),
        .words   (cc_words)
    );

    ccp_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (mac_clear),
        .r_in    (r_clamped),
        .start   (mac_start),
        .m_in    (m_blk_reg),
        .done    (mac_done),
        .acc     (acc)
    );

    assign r_clamped = {cc_words[127:64] & R_CLAMP_HI, cc_words[63:0] & R_CLAMP_LO};
    assign blk_mask  = byte_mask16(n_reg);
    assign blk_in    = {hi_reg, lo_reg} & blk_mask;
    assign text_x    = (ks_reg[bc_reg[1:0]] ^ {hi_reg, lo_reg}) & blk_mask;
    assign tag       = acc[127:0] + pad_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_action != ACT_NONE) begin
                    state_next = (phase_reg == PH_IDLE) ? ST_KS_GO : ST_DISP;
                end
            end
            ST_KS_GO:   state_next = ST_KS_WAIT;
            ST_KS_WAIT: begin
                if (cc_done) state_next = start_flag_reg ? ST_DISP : ST_XOR;
            end
            ST_DISP: begin
                case (act_reg)
                    ACT_AD:     state_next = (n_reg == 5'd0) ? ST_IDLE : ST_ABS_GO;
                    ACT_TEXT: begin
                        if (n_reg == 5'd0) begin
                            state_next = ST_IDLE;
                        end else begin
                            state_next = (bc_reg[1:0] == 2'd0) ? ST_KS_GO : ST_XOR;
                        end
                    end
                    ACT_FINISH: state_next = ST_ABS_GO;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_XOR:      state_next = ST_ABS_GO;
            ST_ABS_GO:   state_next = ST_ABS_WAIT;
            ST_ABS_WAIT: begin
                if (mac_done) begin
                    case (act_reg)
                        ACT_FINISH: state_next = ST_TAG;
                        ACT_TEXT:   state_next = ST_EMIT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TAG:  state_next = ST_EMIT;
            ST_EMIT: if (emit_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        accept    = s_valid && (state_reg == ST_IDLE);
        cc_start  = (state_reg == ST_KS_GO);
        mac_start = (state_reg == ST_ABS_GO);
        mac_clear = (state_reg == ST_KS_WAIT) && cc_done && start_flag_reg;
        emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_IDLE;
            closed_reg     <= 1'b0;
            err_reg        <= 1'b0;
            start_flag_reg <= 1'b0;
            bc_reg         <= '0;
            ad_len_reg     <= '0;
            txt_len_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) start_flag_reg <= (phase_reg == PH_IDLE);
                end
                ST_KS_WAIT: begin
                    if (cc_done && start_flag_reg) begin
                        bc_reg      <= '0;
                        ad_len_reg  <= '0;
                        txt_len_reg <= '0;
                        phase_reg   <= PH_AD;
                        closed_reg  <= 1'b0;
                        err_reg     <= 1'b0;
                    end
                end
                ST_DISP: begin
                    start_flag_reg <= 1'b0;
                    case (act_reg)
                        ACT_AD: begin
                            if (phase_reg == PH_TEXT || closed_reg) err_reg <= 1'b1;
                            if (n_reg != 5'd16) closed_reg <= 1'b1;
                            ad_len_reg <= ad_len_reg + {59'd0, n_reg};
                        end
                        ACT_TEXT: begin
                            if (phase_reg == PH_AD) begin
                                phase_reg <= PH_TEXT;
                            end else if (closed_reg) begin
                                err_reg <= 1'b1;
                            end
                            if (n_reg != 5'd16) begin
                                closed_reg <= 1'b1;
                            end else if (phase_reg == PH_AD) begin
                                closed_reg <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_XOR: begin
                    txt_len_reg <= txt_len_reg + {59'd0, n_reg};
                    bc_reg      <= bc_reg + 32'd1;
                end
                ST_TAG: begin
                    phase_reg  <= PH_IDLE;
                    closed_reg <= 1'b0;
                    err_reg    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg    <= s_action;
            lo_reg     <= s_data_low;
            hi_reg     <= s_data_high;
            n_reg      <= (s_byte_count > 5'd16) ? 5'd16 : s_byte_count;
            ks_ctr_reg <= '0;
        end
        if (state_reg == ST_KS_WAIT && cc_done) begin
            for (int i = 0; i < 4; i++) begin
                ks_reg[i] <= cc_words[128*i +: 128];
            end
            if (start_flag_reg) pad_reg <= cc_words[255:128];
        end
        if (state_reg == ST_DISP) begin
            ks_ctr_reg <= 32'd1 + {2'd0, bc_reg[31:2]};
            if (act_reg == ACT_AD) m_blk_reg <= {1'b1, blk_in};
            if (act_reg == ACT_FINISH) m_blk_reg <= {1'b1, txt_len_reg, ad_len_reg};
        end
        if (state_reg == ST_XOR) begin
            m_blk_reg     <= {1'b1, dec_reg ? blk_in : text_x};
            res_kind_reg  <= 1'b0;
            res_data_reg  <= text_x;
            res_count_reg <= n_reg;
            res_ok_reg    <= 1'b0;
            res_err_reg   <= err_reg;
        end
        if (state_reg == ST_TAG) begin
            res_kind_reg  <= 1'b1;
            res_data_reg  <= tag;
            res_count_reg <= 5'd16;
            res_ok_reg    <= dec_reg && (tag == {hi_reg, lo_reg});
            res_err_reg   <= err_reg;
        end
        if (emit_fire) begin
            m_kind_reg   <= res_kind_reg;
            m_data_reg   <= res_data_reg;
            m_count_reg  <= res_count_reg;
            m_tag_ok_reg <= res_ok_reg;
            m_err_reg    <= res_err_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_out_low     = m_data_reg[63:0];
    assign m_out_high    = m_data_reg[127:64];
    assign m_out_count   = m_count_reg;
    assign m_tag_ok      = m_tag_ok_reg;
    assign m_order_error = m_err_reg;

    a_disp_in_message: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DISP) |-> (phase_reg != PH_IDLE))
        else $error("Beat dispatched outside a message.");

    a_tag_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAG) |=> (phase_reg == PH_IDLE && !err_reg))
        else $error("Finish did not close the message.");

    a_text_no_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_kind_reg) |-> !m_tag_ok_reg)
        else $error("Text beat carries a tag match flag.");

endmodule
`default_nettype wire
